// ----- hdl/square_spiral_index_converter_core_macros.svh -----
// Assertion helpers shared by the converter modules.
// Both expect a clock named clock and an active-high reset named reset.
`ifndef SQUARE_SPIRAL_INDEX_CONVERTER_CORE_MACROS_SVH
`define SQUARE_SPIRAL_INDEX_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication.
`define SSCV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sscv assertion failed");

// Next-cycle implication.
`define SSCV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sscv assertion failed");

`endif

// ----- hdl/sscv_pkg.sv -----
package sscv_pkg;

   localparam int INDEX_W            = 24;
   localparam int COORD_W            = 12;
   localparam int ROOT_W             = 12;   // root of a 24-bit value
   localparam int REM_W              = 15;   // remainder plus two shifted-in bits
   localparam int ROOT_STEPS         = INDEX_W / 2;
   localparam int STEP_W             = $clog2(ROOT_STEPS);
   localparam int LIMIT_W            = 16;
   localparam int LIN_W              = 15;   // linear term of the index formulas
   localparam int IDX_CALC_W         = 27;
   localparam int RING_LIMIT_DEFAULT = 2047;

   localparam logic REQ_INDEX_TO_POINT = 1'b0;
   localparam logic REQ_POINT_TO_INDEX = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic [INDEX_W-1:0]        in_index;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_z;
   } sscv_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_z;
      logic [INDEX_W-1:0]        out_index;
      logic                      range_error;
   } sscv_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sscv_root_stat_type;

endpackage

// ----- hdl/square_spiral_index_converter_core.sv -----
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  sscv_req_type (type, index, x, z)
// rsp      out        rsp_valid/rsp_stall  sscv_rsp_type (x, z, index, range_error)
//
// Index to point: accept, the square-root digit steps, pickup of the root
// done flag, finish.
// Point to index: accept, a multiply step, finish.
// An out-of-range index skips the root and goes straight to finish.
// The index-to-point path runs through the radix-4 root unit; req_stall is high while busy.
// Synchronous active-high reset clears the sequencer and the rsp valid flag.
// A held rsp beat stalls only the finish step; a new req is taken once the
// sequencer is back in idle, even while the previous rsp beat still waits.
`include "square_spiral_index_converter_core_macros.svh"

module square_spiral_index_converter_core #(
   parameter int RING_LIMIT = sscv_pkg::RING_LIMIT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sscv_pkg::sscv_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sscv_pkg::sscv_rsp_type rsp_data
);
   import sscv_pkg::*;

   // first index past the outermost ring: (2*limit+1)^2
   localparam longint EDGE = 2 * longint'(RING_LIMIT) + 1;
   localparam logic [32:0] INDEX_LIMIT = 33'(EDGE * EDGE);
   localparam logic [LIMIT_W-1:0] RING_MAX = LIMIT_W'(RING_LIMIT);
   localparam int CW1 = COORD_W + 1;
   localparam int SQ_W = 2 * CW1;
   localparam int DW = 16;   // signed scratch for the coordinate formulas

   // sequencer
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sscv_rsp_type              rsp_data_ff, rsp_data_in;

   // captured request and intermediate results (no reset needed)
   logic                      type_ff, type_in;
   logic                      err_ff, err_in;
   logic signed [COORD_W-1:0] a_ff, a_in;
   logic signed [COORD_W-1:0] b_ff, b_in;
   logic signed [SQ_W-1:0]    sq_ff, sq_in;
   logic signed [LIN_W-1:0]   lin_ff, lin_in;

   logic                      req_accept;
   logic                      out_free;
   logic                      idx_err;
   logic                      root_start;
   logic [ROOT_W-1:0]         root;
   logic [ROOT_W:0]           rem;
   sscv_root_stat_type        root_stat;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_err    = ({9'd0, req_data.in_index} >= INDEX_LIMIT);
   assign root_start = req_accept && (req_data.req_type == REQ_INDEX_TO_POINT) && !idx_err;

   sscv_root_unit u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (req_data.in_index),
      .root  (root),
      .rem   (rem),
      .stat  (root_stat)
   );

   // ---------------- point to index: zone, square term, linear term -------
   logic signed [CW1-1:0]   a13, b13;
   logic [CW1-1:0]          abs_a, abs_b, ring;
   logic                    z_bottom, z_left, z_top, z_right;
   logic signed [LIN_W-1:0] ax, bx;
   logic signed [CW1-1:0]   m;
   logic signed [LIN_W-1:0] lin;

   always_comb begin
      a13   = {a_ff[COORD_W-1], a_ff};
      b13   = {b_ff[COORD_W-1], b_ff};
      abs_a = a13[CW1-1] ? CW1'(-a13) : CW1'(a13);
      abs_b = b13[CW1-1] ? CW1'(-b13) : CW1'(b13);
      ring  = (abs_a > abs_b) ? abs_a : abs_b;
      ax    = {{(LIN_W-COORD_W){a_ff[COORD_W-1]}}, a_ff};
      bx    = {{(LIN_W-COORD_W){b_ff[COORD_W-1]}}, b_ff};
      // zones tested in order; the origin falls through to zero
      z_bottom = (b13 > 0) && (a13 >= -b13) && (a13 < b13);
      z_left   = (a13 < 0) && (b13 < -a13) && (b13 >= a13);
      z_top    = (b13 < 0) && (a13 <= -b13) && (a13 > b13);
      z_right  = (a13 > 0) && (b13 <= a13) && (b13 > -a13);
      if (z_bottom) begin
         m   = b13;
         lin = (bx <<< 1) + bx - ax;
      end else if (z_left) begin
         m   = a13;
         lin = (ax <<< 1) + ax - bx;
      end else if (z_top) begin
         m   = b13;
         lin = bx + ax;
      end else if (z_right) begin
         m   = a13;
         lin = ax + bx;
      end else begin
         m   = '0;
         lin = '0;
      end
   end

   // ---------------- index to point from root and remainder ---------------
   // n = r^2 + rem; the upper square wins only when rem > r (ties go low),
   // so n - s is rem or rem - (2r+1).
   logic                   up;
   logic [ROOT_W:0]        q;
   logic signed [DW-1:0]   d, half, h, px, pz;

   always_comb begin
      up   = ({1'b0, root} < rem);
      q    = up ? ({1'b0, root} + (ROOT_W+1)'(1)) : {1'b0, root};
      d    = up ? ($signed({3'b000, rem}) - $signed({3'b000, root, 1'b1}))
                : $signed({3'b000, rem});
      half = $signed({{(DW-ROOT_W){1'b0}}, q[ROOT_W:1]});
      h    = half + DW'(1);
      if (!q[0]) begin
         if (d >= 0) begin
            px = half;
            pz = d - half;
         end else begin
            px = half + d;
            pz = -half;
         end
      end else begin
         if (d >= 0) begin
            px = -h;
            pz = h - DW'(1) - d;
         end else begin
            px = -h - d;
            pz = h - DW'(1);
         end
      end
   end

   logic [IDX_CALC_W-1:0] idx_sum;
   assign idx_sum = {sq_ff[IDX_CALC_W-3:0], 2'b00}
                  + {{(IDX_CALC_W-LIN_W){lin_ff[LIN_W-1]}}, lin_ff};

   // ---------------- sequencer ---------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      type_in      = type_ff;
      err_in       = err_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      sq_in        = sq_ff;
      lin_in       = lin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               type_in = req_data.req_type;
               a_in    = req_data.in_x;
               b_in    = req_data.in_z;
               err_in  = 1'b0;
               if (req_data.req_type == REQ_POINT_TO_INDEX) begin
                  state_in = ST_MUL;
               end else if (idx_err) begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (root_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            err_in   = ({{(LIMIT_W-CW1){1'b0}}, ring} > RING_MAX);
            sq_in    = SQ_W'(m) * SQ_W'(m);
            lin_in   = lin;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (err_ff) begin
                  rsp_data_in.range_error = 1'b1;
               end else if (type_ff == REQ_POINT_TO_INDEX) begin
                  rsp_data_in.out_index = idx_sum[INDEX_W-1:0];
               end else begin
                  rsp_data_in.out_x = px[COORD_W-1:0];
                  rsp_data_in.out_z = pz[COORD_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      type_ff     <= type_in;
      err_ff      <= err_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      sq_ff       <= sq_in;
      lin_ff      <= lin_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SSCV_ASSERT_NEXT(a_root_to_done, (state_ff == ST_ROOT) && root_stat.done, state_ff == ST_DONE)
   `SSCV_ASSERT_NOW(a_err_zero, rsp_valid_ff && rsp_data_ff.range_error, (rsp_data_ff.out_x == '0) && (rsp_data_ff.out_z == '0) && (rsp_data_ff.out_index == '0))
   `SSCV_ASSERT_NEXT(a_done_delivers, (state_ff == ST_DONE) && out_free, rsp_valid_ff && (state_ff == ST_IDLE))
   `SSCV_ASSERT_NOW(a_root_busy_in_root, root_stat.busy, state_ff == ST_ROOT)

endmodule

// ----- hdl/sscv_root_unit.sv -----
`include "square_spiral_index_converter_core_macros.svh"

module sscv_root_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [sscv_pkg::INDEX_W-1:0]       value,
   output logic [sscv_pkg::ROOT_W-1:0]        root,
   output logic [sscv_pkg::ROOT_W:0]          rem,
   output sscv_pkg::sscv_root_stat_type       stat
);
   import sscv_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [INDEX_W-1:0]  v_ff, v_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [REM_W-1:0]    rem_ff, rem_in;

   logic [REM_W-1:0]    rem_sh;
   logic [REM_W-1:0]    trial;
   logic                fit;
   logic                last;

   // one radix-4 digit per cycle: shift in two bits, try (4*root + 1)
   assign rem_sh = {rem_ff[REM_W-3:0], v_ff[INDEX_W-1 -: 2]};
   assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign fit    = (rem_sh >= trial);
   assign last   = (step_ff == STEP_W'(ROOT_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      v_in    = v_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         v_in    = value;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + STEP_W'(1);
         v_in    = {v_ff[INDEX_W-3:0], 2'b00};
         root_in = {root_ff[ROOT_W-2:0], fit};
         rem_in  = fit ? (rem_sh - trial) : rem_sh;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign root      = root_ff;
   assign rem       = rem_ff[ROOT_W:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `SSCV_ASSERT_NOW(a_no_restart, start, !busy_ff)
   `SSCV_ASSERT_NEXT(a_last_step_done, busy_ff && last && !start, done_ff && !busy_ff)
   `SSCV_ASSERT_NOW(a_rem_bound, done_ff, rem_ff <= {{(REM_W-ROOT_W-1){1'b0}}, root_ff, 1'b0})

endmodule
